// ----- hw/rtl/bir_pkg.sv -----
`timescale 1ns / 1ps

package bir_pkg;

	// Fixed field widths of the channels and the configuration port.
	localparam int COORD_W   = 11;
	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;
	localparam int SIZE_W    = 9;
	localparam int RATE_W    = 10;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;

	// The output coordinate is scaled by one hundred before the divide.
	localparam int PERCENT   = 100;
	localparam int PERCENT_W = 7;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_FRAC_BITS  = 8;

	localparam logic [SIZE_W-1:0] RST_SRC_WIDTH  = 9'd256;
	localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT = 9'd256;
	localparam logic [RATE_W-1:0] RST_RATE       = 10'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH    = 2'd0,
		REG_SRC_HEIGHT   = 2'd1,
		REG_RATE_PERCENT = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MAP,
		ST_READ,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;      // write the input pixel into the frame store
		logic       start;     // start mapping the sample coordinate
		logic       map;       // register the clamped source position
		logic       rd;        // read one neighbour and weight it
		logic [1:0] corner;    // bit 0: right neighbour, bit 1: lower neighbour
		logic       load_out;  // move the blended pixel into the output register
	} cmd_t;

	typedef struct packed {
		logic div_busy;
	} sts_t;

endpackage

// ----- hw/rtl/bir_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The quotient builds up in
// the numerator register as its bits shift out.
module bir_div import bir_pkg::*; #(
	parameter int NUM_W = 26,
	parameter int DEN_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quot,
	output logic             busy
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			if (fits) begin
				rem_q <= DEN_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DEN_W-1:0];
			end
		end
	end

	assign quot = num_q;
	assign busy = cnt_q != '0;

endmodule

// ----- hw/rtl/bir_dp.sv -----
`timescale 1ns / 1ps

// Datapath: configuration registers, coordinate dividers, frame store,
// weighting pipeline and output register.
module bir_dp import bir_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [COORD_W-1:0]   col,
	input  logic [COORD_W-1:0]   row,
	input  logic [CH_W-1:0]      red,
	input  logic [CH_W-1:0]      green,
	input  logic [CH_W-1:0]      blue,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic [CH_W-1:0]      out_red,
	output logic [CH_W-1:0]      out_green,
	output logic [CH_W-1:0]      out_blue
);

	localparam int XW          = $clog2(MAX_WIDTH);
	localparam int YW          = $clog2(MAX_HEIGHT);
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CALC_W      = ADDR_W + COORD_W + 2;
	localparam int NUM_W       = COORD_W + PERCENT_W + FRAC_BITS;
	localparam int WGT_W       = 2 * FRAC_BITS + 1;
	localparam int ACC_W       = 2 * FRAC_BITS + CH_W + 1;
	localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

	// Configuration registers.
	logic [SIZE_W-1:0] src_width_q;
	logic [SIZE_W-1:0] src_height_q;
	logic [RATE_W-1:0] rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= RST_SRC_WIDTH;
			src_height_q <= RST_SRC_HEIGHT;
			rate_q       <= RST_RATE;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH:    src_width_q  <= cfg_data[SIZE_W-1:0];
				REG_SRC_HEIGHT:   src_height_q <= cfg_data[SIZE_W-1:0];
				REG_RATE_PERCENT: rate_q       <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// Last valid anchor in each direction, from the saturated image size.
	logic [XW-1:0] lim_x_q;
	logic [YW-1:0] lim_y_q;
	logic [XW-1:0] lim_x_d;
	logic [YW-1:0] lim_y_d;

	always_comb begin
		if (src_width_q < SIZE_W'(2)) begin
			lim_x_d = '0;
		end else if (32'(src_width_q) > 32'(MAX_WIDTH)) begin
			lim_x_d = XW'(MAX_WIDTH - 2);
		end else begin
			lim_x_d = XW'(src_width_q - SIZE_W'(2));
		end
		if (src_height_q < SIZE_W'(2)) begin
			lim_y_d = '0;
		end else if (32'(src_height_q) > 32'(MAX_HEIGHT)) begin
			lim_y_d = YW'(MAX_HEIGHT - 2);
		end else begin
			lim_y_d = YW'(src_height_q - SIZE_W'(2));
		end
	end

	always_ff @(posedge clk) begin
		lim_x_q <= lim_x_d;
		lim_y_q <= lim_y_d;
	end

	// Coordinate mapping: coord * 100 * 2^FRAC_BITS / rate.
	logic [NUM_W-1:0]  num_x;
	logic [NUM_W-1:0]  num_y;
	logic [RATE_W-1:0] den;
	logic [NUM_W-1:0]  quot_x;
	logic [NUM_W-1:0]  quot_y;
	logic              busy_x;
	logic              busy_y;

	assign num_x = (NUM_W'(col) * NUM_W'(PERCENT)) << FRAC_BITS;
	assign num_y = (NUM_W'(row) * NUM_W'(PERCENT)) << FRAC_BITS;
	assign den   = (rate_q == '0) ? RATE_W'(1) : rate_q;

	bir_div #(
		.NUM_W(NUM_W),
		.DEN_W(RATE_W)
	) u_div_x (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start),
		.num   (num_x),
		.den   (den),
		.quot  (quot_x),
		.busy  (busy_x)
	);

	bir_div #(
		.NUM_W(NUM_W),
		.DEN_W(RATE_W)
	) u_div_y (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start),
		.num   (num_y),
		.den   (den),
		.quot  (quot_y),
		.busy  (busy_y)
	);

	assign sts.div_busy = busy_x | busy_y;

	// Clamp to the last pixel pair and split into anchor and fraction.
	logic [XW-1:0]        ix_q;
	logic [YW-1:0]        iy_q;
	logic [FRAC_BITS-1:0] fx_q;
	logic [FRAC_BITS-1:0] fy_q;
	logic                 over_x;
	logic                 over_y;

	assign over_x = quot_x > (NUM_W'(lim_x_q) << FRAC_BITS);
	assign over_y = quot_y > (NUM_W'(lim_y_q) << FRAC_BITS);

	always_ff @(posedge clk) begin
		if (cmd.map) begin
			ix_q <= over_x ? lim_x_q : quot_x[FRAC_BITS +: XW];
			fx_q <= over_x ? '0 : quot_x[FRAC_BITS-1:0];
			iy_q <= over_y ? lim_y_q : quot_y[FRAC_BITS +: YW];
			fy_q <= over_y ? '0 : quot_y[FRAC_BITS-1:0];
		end
	end

	// Frame store, addressed row * MAX_WIDTH + col.
	logic [PIX_W-1:0]  mem [STORE_DEPTH];
	logic [CALC_W-1:0] waddr_full;
	logic [CALC_W-1:0] raddr_full;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic              wr_en;
	logic [XW-1:0]     rd_col;
	logic [YW-1:0]     rd_row;

	assign waddr_full = CALC_W'(row) * CALC_W'(MAX_WIDTH) + CALC_W'(col);
	assign waddr      = waddr_full[ADDR_W-1:0];
	assign wr_en      = cmd.load && (CALC_W'(col) < CALC_W'(MAX_WIDTH))
	                    && (CALC_W'(row) < CALC_W'(MAX_HEIGHT));

	assign rd_col     = XW'(ix_q + XW'(cmd.corner[0]));
	assign rd_row     = YW'(iy_q + YW'(cmd.corner[1]));
	assign raddr_full = CALC_W'(rd_row) * CALC_W'(MAX_WIDTH) + CALC_W'(rd_col);
	assign raddr      = raddr_full[ADDR_W-1:0];

	logic [PIX_W-1:0] rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= {red, green, blue};
		end
		if (cmd.rd) begin
			rd_s1 <= mem[raddr];
		end
	end

	// Corner weight, registered alongside the read data.
	logic [FRAC_BITS:0] wx;
	logic [FRAC_BITS:0] wy;
	logic [WGT_W-1:0]   wgt_s1;
	logic               v_s1;
	logic               first_s1;

	assign wx = cmd.corner[0] ? {1'b0, fx_q} : ONE_FX - {1'b0, fx_q};
	assign wy = cmd.corner[1] ? {1'b0, fy_q} : ONE_FX - {1'b0, fy_q};

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			wgt_s1 <= WGT_W'(wx) * WGT_W'(wy);
		end
	end

	// Per-channel products, then the running sum over four corners.
	logic [ACC_W-1:0] prod_s2 [3];
	logic [ACC_W-1:0] acc_q   [3];
	logic             v_s2;
	logic             first_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			v_s2     <= 1'b0;
			first_s2 <= 1'b0;
		end else begin
			v_s1     <= cmd.rd;
			first_s1 <= cmd.rd && (cmd.corner == 2'd0);
			v_s2     <= v_s1;
			first_s2 <= first_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			if (v_s1) begin
				prod_s2[ch] <= ACC_W'(rd_s1[PIX_W-CH_W*(ch+1) +: CH_W]) * ACC_W'(wgt_s1);
			end
			if (v_s2) begin
				acc_q[ch] <= first_s2 ? prod_s2[ch] : ACC_W'(acc_q[ch] + prod_s2[ch]);
			end
		end
	end

	// Output register: drop the 2*FRAC_BITS fraction bits.
	logic [CH_W-1:0] out_red_q;
	logic [CH_W-1:0] out_green_q;
	logic [CH_W-1:0] out_blue_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_red_q   <= acc_q[0][2*FRAC_BITS +: CH_W];
			out_green_q <= acc_q[1][2*FRAC_BITS +: CH_W];
			out_blue_q  <= acc_q[2][2*FRAC_BITS +: CH_W];
		end
	end

	assign out_red   = out_red_q;
	assign out_green = out_green_q;
	assign out_blue  = out_blue_q;

endmodule

// ----- hw/rtl/bir_ctrl.sv -----
`timescale 1ns / 1ps

// Sequencer: accepts beats, steps a sample through divide, clamp, four
// neighbour reads and the pipeline drain, and owns the output valid.
module bir_ctrl import bir_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic operation,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q;
	state_t     state_d;
	logic [1:0] cnt_q;
	logic [1:0] cnt_d;
	logic       out_valid_q;
	logic       out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd         = '0;
		in_stall    = 1'b1;
		out_valid_d = out_valid_q && out_stall;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (operation == OP_SAMPLE) begin
						cmd.start = 1'b1;
						state_d   = ST_DIV;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					state_d = ST_MAP;
				end
			end
			ST_MAP: begin
				cmd.map = 1'b1;
				cnt_d   = '0;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.rd     = 1'b1;
				cmd.corner = cnt_q;
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == 2'd3) begin
					cnt_d   = '0;
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == 2'd1) begin
					cnt_d   = '0;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hw/rtl/bilinear_image_resize.sv -----
`timescale 1ns / 1ps

// Bilinear RGB image scaler with an on-chip source frame store.
// Input channel (in_valid / in_stall): each beat is either a load, which
// writes red/green/blue into the frame store at (col, row), or a sample,
// which names an output pixel. Loads outside the store are dropped.
// Output channel (out_valid / out_stall): one beat per sample carrying the
// interpolated, truncated out_red/out_green/out_blue. Loads give no beat.
// Configuration: cfg_we writes cfg_data into the register cfg_index selects
// (source width, source height, scale in percent); write only while idle.
// Throughput: loads stream at one beat per cycle while the sequencer is
// idle. A sample holds the input through the bit-serial divide of the
// coordinate by the rate, the clamp, the four reads through the one read
// port of the frame store, the pipeline drain and the output load.
// The finished pixel sits in an output register, so the input reopens while
// it waits; if the receiver stalls, the next sample is held just before
// its result would overwrite the pending one.
// Reset clears the sequencer, output valid and registers (256, 256, 100);
// the frame store is not cleared and must be loaded before sampling.
module bilinear_image_resize import bir_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 operation,
	input  logic [COORD_W-1:0]   col,
	input  logic [COORD_W-1:0]   row,
	input  logic [CH_W-1:0]      red,
	input  logic [CH_W-1:0]      green,
	input  logic [CH_W-1:0]      blue,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CH_W-1:0]      out_red,
	output logic [CH_W-1:0]      out_green,
	output logic [CH_W-1:0]      out_blue
);

	cmd_t cmd;
	sts_t sts;

	// The sequencer decides what happens each cycle; the datapath holds
	// every payload register and the frame store.
	bir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation(operation),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bir_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.col      (col),
		.row      (row),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.cmd      (cmd),
		.sts      (sts),
		.out_red  (out_red),
		.out_green(out_green),
		.out_blue (out_blue)
	);

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import bir_pkg::*;

	// The block is built with its default store size and fraction width.
	localparam int MAX_W = DEF_MAX_WIDTH;
	localparam int MAX_H = DEF_MAX_HEIGHT;
	localparam int FRAC  = DEF_FRAC_BITS;
	localparam logic [63:0] ONE = 64'd1 << FRAC;

	// The wait covers a sample's whole pass through the block; the
	// margin covers a load that may still be in flight when the last
	// result has already come out.
	localparam int SETTLE_CYCLES = DEF_FRAC_BITS + 27 + 8;
	localparam int LIMIT_CYCLES  = 600_000;

	// Index three is not decoded by the block; writes to it must do nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               operation;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	logic [CH_W-1:0]    red;
	logic [CH_W-1:0]    green;
	logic [CH_W-1:0]    blue;
	logic               out_valid;
	logic               out_stall;
	logic [CH_W-1:0]    out_red;
	logic [CH_W-1:0]    out_green;
	logic [CH_W-1:0]    out_blue;

	// Our own copy of the block's state: the frame store, a map of which
	// entries have been written, and the three configuration registers.
	logic [PIX_W-1:0]  frame_mem [0:MAX_W*MAX_H-1];
	bit                pixel_written [0:MAX_W*MAX_H-1];
	logic [SIZE_W-1:0] width_reg = RST_SRC_WIDTH;
	logic [SIZE_W-1:0] height_reg = RST_SRC_HEIGHT;
	logic [RATE_W-1:0] rate_reg = RST_RATE;

	// Pixels the block still owes us, oldest first.
	rgb_t pending_pixels [$];

	int mismatch_count = 0;
	int cycle_count = 0;
	int hold_off_req = 0;

	// in_held is set while in_valid is still high from the previous beat.
	// The calm flags switch a side into a stretch with no random idling.
	bit in_held = 1'b0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;

	bilinear_image_resize i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.col       (col),
		.row       (row),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Sizes outside [2, max] are saturated when the block uses them.
	function automatic int unsigned used_size(logic [SIZE_W-1:0] v, int unsigned maxv);
		if (v < 2)
			return 2;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// A rate of zero behaves as one; everything else is taken as written.
	function automatic int unsigned active_rate();
		return (rate_reg == 0) ? 1 : rate_reg;
	endfunction

	// Output coordinate to source position, FRAC fraction bits, clamped so
	// that the right and lower neighbours always stay inside the image.
	function automatic logic [63:0] map_to_source(logic [COORD_W-1:0] coord,
		int unsigned size, int unsigned rate);
		logic [63:0] pos;
		logic [63:0] lim;
		pos = ((64'(coord) * PERCENT) << FRAC) / rate;
		lim = 64'(size - 2) << FRAC;
		return (pos > lim) ? lim : pos;
	endfunction

	// Blend of the four neighbours of one channel, truncated.
	function automatic logic [CH_W-1:0] mix_channel(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
		logic [CH_W-1:0] c, logic [CH_W-1:0] d, logic [63:0] fx, logic [63:0] fy);
		logic [63:0] top;
		logic [63:0] bottom;
		logic [63:0] acc;
		top    = 64'(a) * (ONE - fx) + 64'(b) * fx;
		bottom = 64'(c) * (ONE - fx) + 64'(d) * fx;
		acc    = (top * (ONE - fy) + bottom * fy) >> (2 * FRAC);
		return acc[CH_W-1:0];
	endfunction

	function automatic rgb_t interpolate_pixel(logic [COORD_W-1:0] c, logic [COORD_W-1:0] r);
		logic [63:0] xf;
		logic [63:0] yf;
		logic [63:0] fx;
		logic [63:0] fy;
		int unsigned ix;
		int unsigned iy;
		logic [PIX_W-1:0] pa;
		logic [PIX_W-1:0] pb;
		logic [PIX_W-1:0] pc;
		logic [PIX_W-1:0] pd;
		rgb_t px;
		xf = map_to_source(c, used_size(width_reg, MAX_W), active_rate());
		yf = map_to_source(r, used_size(height_reg, MAX_H), active_rate());
		ix = xf >> FRAC;
		iy = yf >> FRAC;
		fx = xf & (ONE - 1);
		fy = yf & (ONE - 1);
		pa = frame_mem[iy * MAX_W + ix];
		pb = frame_mem[iy * MAX_W + ix + 1];
		pc = frame_mem[(iy + 1) * MAX_W + ix];
		pd = frame_mem[(iy + 1) * MAX_W + ix + 1];
		px.r = mix_channel(pa[23:16], pb[23:16], pc[23:16], pd[23:16], fx, fy);
		px.g = mix_channel(pa[15:8], pb[15:8], pc[15:8], pd[15:8], fx, fy);
		px.b = mix_channel(pa[7:0], pb[7:0], pc[7:0], pd[7:0], fx, fy);
		return px;
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Sends one beat and updates the predictor once the block has taken it.
	// in_valid is left high afterwards, so a beat that follows with no gap
	// keeps valid up instead of dropping and raising it in the same step.
	task automatic send_beat(input logic op, input logic [COORD_W-1:0] c,
		input logic [COORD_W-1:0] r, input logic [PIX_W-1:0] px);
		int gap;
		if ($urandom_range(0, 39) == 0)
			in_calm = !in_calm;
		gap = in_calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			if (in_held) begin
				in_valid <= 1'b0;
				in_held = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		col       <= c;
		row       <= r;
		red       <= px[23:16];
		green     <= px[15:8];
		blue      <= px[7:0];
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		in_held = 1'b1;
		if (op == OP_SAMPLE) begin
			pending_pixels.push_back(interpolate_pixel(c, r));
		end else if (c < MAX_W && r < MAX_H) begin
			// Loads beyond the store are dropped; loads beyond the image
			// but inside the store are kept.
			frame_mem[r * MAX_W + c] = px;
			pixel_written[r * MAX_W + c] = 1'b1;
		end
	endtask

	task automatic load_pixel(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r);
		send_beat(OP_LOAD, c, r, PIX_W'($urandom));
	endtask

	// Loads whichever of the four neighbours a sample at (c, r) reads that
	// were never written, so every read of the block sees defined data.
	task automatic cover_sample(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r);
		int unsigned ix;
		int unsigned iy;
		ix = 32'(map_to_source(c, used_size(width_reg, MAX_W), active_rate()) >> FRAC);
		iy = 32'(map_to_source(r, used_size(height_reg, MAX_H), active_rate()) >> FRAC);
		for (int dy = 0; dy < 2; dy++)
			for (int dx = 0; dx < 2; dx++)
				if (!pixel_written[(iy + dy) * MAX_W + ix + dx])
					load_pixel(COORD_W'(ix + dx), COORD_W'(iy + dy));
	endtask

	// The color fields of a sample are ignored, so they carry noise.
	task automatic sample_at(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r);
		cover_sample(c, r);
		send_beat(OP_SAMPLE, c, r, PIX_W'($urandom));
	endtask

	task automatic release_input();
		if (in_held) begin
			in_valid <= 1'b0;
			in_held = 1'b0;
		end
	endtask

	// Stops sending, waits for every owed pixel, then lets the block settle
	// so that the registers may be written again.
	task automatic wait_for_results();
		release_input();
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all three registers, then the undecoded index if asked, on consecutive
	// edges; write enable stays high across them and drops once at the end.
	task automatic program_regs(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
		input logic [CFG_W-1:0] rt, input bit poke_unused);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SRC_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_SRC_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_index <= REG_RATE_PERCENT;
		cfg_data  <= rt;
		@(posedge clk);
		if (poke_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_data  <= CFG_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		width_reg  = w[SIZE_W-1:0];
		height_reg = h[SIZE_W-1:0];
		rate_reg   = rt[RATE_W-1:0];
	endtask

	// Mostly coordinates inside the scaled image, with a share drawn from
	// the full field so that the clamp and every coordinate bit get hit.
	function automatic logic [COORD_W-1:0] pick_coord(logic [SIZE_W-1:0] size_reg);
		int unsigned span;
		span = used_size(size_reg, MAX_W) * active_rate() / 100 + 2;
		if (span > 2047)
			span = 2047;
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(0, span);
		return COORD_W'($urandom);
	endfunction

	// Random traffic on the current image: mostly samples, the rest loads
	// inside the image, elsewhere in the store, or anywhere in the field.
	task automatic run_mix(input int count);
		int unsigned w;
		int unsigned h;
		w = used_size(width_reg, MAX_W);
		h = used_size(height_reg, MAX_H);
		repeat (count) begin
			if ($urandom_range(0, 9) < 8) begin
				sample_at(pick_coord(width_reg), pick_coord(height_reg));
			end else begin
				case ($urandom_range(0, 2))
					0: load_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1));
					1: load_pixel($urandom_range(0, MAX_W - 1), $urandom_range(0, MAX_H - 1));
					default: load_pixel(COORD_W'($urandom), COORD_W'($urandom));
				endcase
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Output side: stalls at random, checks every beat it accepts
	// ------------------------------------------------------------------

	initial begin : receiver
		int stall_left;
		int hold_left;
		rgb_t want;
		stall_left = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (pending_pixels.size() == 0) begin
					$display("%0t: result beat with no sample pending, got %h %h %h",
						$time, out_red, out_green, out_blue);
					mismatch_count++;
				end else begin
					want = pending_pixels.pop_front();
					if (out_red !== want.r) begin
						$display("%0t: out_red expected %0d actual %0d", $time, want.r, out_red);
						mismatch_count++;
					end
					if (out_green !== want.g) begin
						$display("%0t: out_green expected %0d actual %0d",
							$time, want.g, out_green);
						mismatch_count++;
					end
					if (out_blue !== want.b) begin
						$display("%0t: out_blue expected %0d actual %0d",
							$time, want.b, out_blue);
						mismatch_count++;
					end
				end
				if ($urandom_range(0, 39) == 0)
					out_calm = !out_calm;
				stall_left = out_calm ? 0 : $urandom_range(0, 18);
			end
			// A long hold-off requested by a test is counted here, in
			// cycles, independent of what the sender is doing.
			if (hold_off_req > 0) begin
				hold_left = hold_off_req;
				hold_off_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Runs on the reset registers (256 x 256 at 100 percent), so the mapping
	// is exact. Fills the two store corners, tries loads just past the store
	// that a truncated address would alias onto the first corner and one far
	// past it, then samples both corners and a coordinate far past the image.
	task automatic test_reset_defaults();
		logic [PIX_W-1:0] corner_px [9];
		corner_px = '{24'hFFFFFF, 24'h000000, 24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'h808080, 24'h7F7F7F, 24'h010203, 24'hFEDCBA};
		for (int i = 0; i < 9; i++)
			send_beat(OP_LOAD, i % 3, i / 3, corner_px[i]);
		send_beat(OP_LOAD, 254, 254, 24'h123456);
		send_beat(OP_LOAD, 255, 254, 24'hABCDEF);
		send_beat(OP_LOAD, 254, 255, 24'hFFFFFF);
		send_beat(OP_LOAD, 255, 255, 24'h000001);
		send_beat(OP_LOAD, 256, 0, 24'h55AA55);
		send_beat(OP_LOAD, 0, 256, 24'hAA55AA);
		send_beat(OP_LOAD, 2047, 2047, 24'hC3C3C3);
		sample_at(0, 0);
		sample_at(1, 1);
		sample_at(1, 0);
		sample_at(255, 255);
		sample_at(2047, 2047);
		wait_for_results();
	endtask

	// Sizes below two and above the store, and a zero rate. The second
	// setting writes all-ones data, of which the width register keeps only
	// its own bits, and the largest rate the register holds.
	task automatic test_size_saturation();
		program_regs(10'd1, 10'd0, 10'd0, 1'b0);
		run_mix(30);
		wait_for_results();
		program_regs(10'h3FF, 10'h200, 10'h3FF, 1'b0);
		run_mix(40);
		wait_for_results();
	endtask

	// A tall, narrow image at a high rate (800 percent) and at the bottom of the rate range.
	task automatic test_extreme_rates();
		program_regs(10'd2, 10'd256, 10'd800, 1'b0);
		run_mix(40);
		wait_for_results();
		program_regs(10'd2, 10'd256, 10'd1, 1'b0);
		run_mix(20);
		wait_for_results();
	endtask

	// A write to the undecoded index follows the real ones; the samples
	// after it show whether any register moved.
	task automatic test_unknown_register();
		program_regs(10'd12, 10'd9, 10'd150, 1'b1);
		run_mix(30);
		wait_for_results();
	endtask

	// Small random images at random rates, each with its own traffic.
	task automatic test_random_scaling();
		repeat (6) begin
			program_regs(CFG_W'($urandom_range(2, 24)), CFG_W'($urandom_range(2, 24)),
				($urandom_range(0, 4) == 0) ? CFG_W'($urandom_range(1, 1023))
					: CFG_W'($urandom_range(1, 800)), 1'b0);
			run_mix(25);
			wait_for_results();
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering samples back to back, so the pending result blocks the next
	// sample and the input stalls. Then the sender pauses until everything
	// owed has arrived before it resumes.
	task automatic test_backpressure();
		logic [COORD_W-1:0] bp_col [12];
		logic [COORD_W-1:0] bp_row [12];
		program_regs(10'd20, 10'd14, 10'd333, 1'b0);
		for (int i = 0; i < 12; i++) begin
			bp_col[i] = pick_coord(width_reg);
			bp_row[i] = pick_coord(height_reg);
			cover_sample(bp_col[i], bp_row[i]);
		end
		wait_for_results();
		hold_off_req = 400;
		in_calm = 1'b1;
		for (int i = 0; i < 12; i++)
			sample_at(bp_col[i], bp_row[i]);
		wait_for_results();
		run_mix(30);
		wait_for_results();
	endtask

	// ------------------------------------------------------------------
	// Sequence and end of run
	// ------------------------------------------------------------------

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_SRC_WIDTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		operation = OP_LOAD;
		col       = '0;
		row       = '0;
		red       = '0;
		green     = '0;
		blue      = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_size_saturation();
		test_extreme_rates();
		test_unknown_register();
		test_random_scaling();
		test_backpressure();
		wait_for_results();

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog on the cycle count.
	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/bir_pkg.sv
hw/rtl/bir_div.sv
hw/rtl/bir_dp.sv
hw/rtl/bir_ctrl.sv
hw/rtl/bilinear_image_resize.sv
bench/tb_top.sv
